// ===== rtl/core/rtp_pkg.sv =====
`default_nettype none

package rtp_pkg;

  // Angle word: signed Q3.13 radians
  localparam int ANGLE_W = 16;

  // Fraction bits added below the integer coordinates in the CORDIC datapath
  localparam int GUARD_BITS = 16;

  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;

  // round(atan(2^-i) * 8192), zero from i = 14 on
  localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [0:31] = '{
    16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019, 16'sd511, 16'sd256, 16'sd128, 16'sd64,
    16'sd32,   16'sd16,   16'sd8,    16'sd4,    16'sd2,   16'sd1,   16'sd0,   16'sd0,
    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,   16'sd0,   16'sd0,   16'sd0,
    16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,   16'sd0,   16'sd0,   16'sd0
  };

  // How the final angle is formed
  typedef enum logic [2:0] {
    ANG_CORDIC,
    ANG_ZERO,
    ANG_PI,
    ANG_POS_HALF,
    ANG_NEG_HALF
  } angle_case_t;

endpackage

`default_nettype wire

// ===== rtl/core/rtp_cordic_stage.sv =====
`default_nettype none

module rtp_cordic_stage #(
  parameter int CW    = 34,
  parameter int SHIFT = 0
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [CW-1:0]               x_in,
  input  wire logic signed [CW-1:0]               y_in,
  input  wire logic signed [rtp_pkg::ANGLE_W-1:0] z_in,
  output logic signed [CW-1:0]                    x_out,
  output logic signed [CW-1:0]                    y_out,
  output logic signed [rtp_pkg::ANGLE_W-1:0]      z_out
);
  import rtp_pkg::*;

  localparam logic signed [ANGLE_W-1:0] ATAN = ATAN_TABLE[SHIFT];

  logic signed [CW-1:0] x_sh;
  logic signed [CW-1:0] y_sh;

  // Arithmetic shifts round toward minus infinity
  assign x_sh = x_in >>> SHIFT;
  assign y_sh = y_in >>> SHIFT;

  // Rotate toward the x axis: direction follows the sign of y
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[CW-1]) begin
        x_out <= x_in + y_sh;
        y_out <= y_in - x_sh;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - y_sh;
        y_out <= y_in + x_sh;
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rtp_sqrt_stage.sv =====
`default_nettype none

module rtp_sqrt_stage #(
  parameter int W = 16
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [2*W-1:0]   n_in,
  input  wire logic [W+1:0]     rem_in,
  input  wire logic [W-1:0]     root_in,
  output logic [2*W-1:0]        n_out,
  output logic [W+1:0]          rem_out,
  output logic [W-1:0]          root_out
);

  logic [W+3:0] rem_sh;
  logic [W+3:0] trial;
  logic [W+3:0] diff;
  logic         take;

  // Bring down the next two radicand bits and try a one in this root bit
  assign rem_sh = {rem_in, n_in[2*W-1:2*W-2]};
  assign trial  = {2'b00, root_in, 2'b01};
  assign take   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      n_out <= {n_in[2*W-3:0], 2'b00};
      if (take) begin
        rem_out  <= diff[W+1:0];
        root_out <= {root_in[W-2:0], 1'b1};
      end else begin
        rem_out  <= rem_sh[W+1:0];
        root_out <= {root_in[W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rtp_out_buf.sv =====
`default_nettype none

module rtp_out_buf #(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_data,
  output logic               in_ready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [DW-1:0]      m_tdata
);

  logic          skid_valid;
  logic [DW-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= in_valid;
      end else if (in_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid   <= 1'b1;
      skid_valid <= 1'b0;
    end
  end

  // Park the incoming result in the skid slot while the output is stalled
  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end else if (m_tready) begin
      m_tdata <= skid_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rect_to_polar_converter.sv =====
`default_nettype none

// Rectangular to polar converter. Each input transaction carries one point
// (x_coord, y_coord, signed DATA_WIDTH-bit integers) and yields exactly one
// output transaction with the magnitude round(sqrt(x^2 + y^2)) as an unsigned
// integer and the angle atan2(y, x) in radians, signed Q3.13, saturated to
// -pi .. +pi. The magnitude is exact (a digit-by-digit integer square root,
// one root bit per stage); the angle comes from a vectoring CORDIC of
// ITERATIONS stages. The origin gives angle 0, the y axis +/-pi/2 and the
// negative x axis +pi. The block takes one transaction every cycle while the
// output buffer has room. Its depth is set by the longer of the square-root
// and CORDIC stage chains, which run side by side. A two-entry output buffer
// lets the pipeline keep filling while a result waits; the block keeps no
// state beyond the items in flight.
module rect_to_polar_converter #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  // s_tdata, from bit 0: x_coord, y_coord, zero pad to whole bytes
  input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  // m_tdata, from bit 0: magnitude, angle, zero pad to whole bytes
  output logic [((DATA_WIDTH+rtp_pkg::ANGLE_W+7)/8)*8-1:0] m_tdata
);
  import rtp_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int CW     = DATA_WIDTH + GUARD_BITS + 2;
  localparam int L      = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;
  localparam int OUT_TW = ((DATA_WIDTH + ANGLE_W + 7) / 8) * 8;

  // Whole pipeline advances together unless the output buffer is full
  logic en;

  // Stage 0: input registers
  logic                s0_valid;
  logic signed [W-1:0] x0;
  logic signed [W-1:0] y0;

  // Stage 1: squares
  logic                s1_valid;
  logic signed [W-1:0] x1;
  logic signed [W-1:0] y1;
  logic [2*W-1:0]      ax2;
  logic [2*W-1:0]      ay2;
  logic [W-1:0]        ax;
  logic [W-1:0]        ay;

  // Stage 2 and iteration stages; index 0 is stage 2
  logic                      it_valid [0:L];
  logic [2*W-1:0]            n_p      [0:L];
  logic [W+1:0]              rem_p    [0:L];
  logic [W-1:0]              root_p   [0:L];
  logic signed [CW-1:0]      cx_p     [0:L];
  logic signed [CW-1:0]      cy_p     [0:L];
  logic signed [ANGLE_W-1:0] cz_p     [0:L];
  angle_case_t               case_p   [0:L];

  // Stage 2 CORDIC setup
  logic signed [CW-1:0]      xg;
  logic signed [CW-1:0]      yg;
  logic signed [CW-1:0]      cx_init;
  logic signed [CW-1:0]      cy_init;
  logic signed [ANGLE_W-1:0] cz_init;
  angle_case_t               case_init;

  // Final stage
  logic                      fin_valid;
  logic [W-1:0]              fin_mag;
  logic signed [ANGLE_W-1:0] fin_angle;
  logic [W-1:0]              fin_mag_next;
  logic signed [ANGLE_W-1:0] fin_angle_next;
  logic [OUT_TW-1:0]         fin_data;

  assign s_tready = en;

  // Valid bits travel with the data and hold when the pipeline stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      fin_valid <= 1'b0;
      for (int k = 0; k <= L; k++) begin
        it_valid[k] <= 1'b0;
      end
    end else if (en) begin
      s0_valid    <= s_tvalid;
      s1_valid    <= s0_valid;
      it_valid[0] <= s1_valid;
      for (int k = 0; k < L; k++) begin
        it_valid[k+1] <= it_valid[k];
      end
      fin_valid <= it_valid[L];
    end
  end

  // Stage 0: capture the point
  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= s_tdata[W-1:0];
      y0 <= s_tdata[2*W-1:W];
    end
  end

  // Stage 1: absolute values as unsigned words, then square them
  assign ax = x0[W-1] ? (~x0 + W'(1)) : x0;
  assign ay = y0[W-1] ? (~y0 + W'(1)) : y0;

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= x0;
      y1  <= y0;
      ax2 <= (2*W)'(ax) * (2*W)'(ax);
      ay2 <= (2*W)'(ay) * (2*W)'(ay);
    end
  end

  // Stage 2: radicand sum and CORDIC entry with the left-half-plane rotation
  assign xg = CW'(x1) <<< GUARD_BITS;
  assign yg = CW'(y1) <<< GUARD_BITS;

  always_comb begin
    if (x1[W-1]) begin
      if (!y1[W-1] && (y1 != '0)) begin
        cx_init = yg;
        cy_init = -xg;
        cz_init = HALF_PI_Q13;
      end else begin
        cx_init = -yg;
        cy_init = xg;
        cz_init = -HALF_PI_Q13;
      end
    end else begin
      cx_init = xg;
      cy_init = yg;
      cz_init = '0;
    end
  end

  always_comb begin
    priority if (y1 == '0) begin
      case_init = x1[W-1] ? ANG_PI : ANG_ZERO;
    end else if (x1 == '0) begin
      case_init = y1[W-1] ? ANG_NEG_HALF : ANG_POS_HALF;
    end else begin
      case_init = ANG_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_p[0]    <= ax2 + ay2;
      rem_p[0]  <= '0;
      root_p[0] <= '0;
      cx_p[0]   <= cx_init;
      cy_p[0]   <= cy_init;
      cz_p[0]   <= cz_init;
      case_p[0] <= case_init;
    end
  end

  // Iteration stages: a root bit and a CORDIC rotation per stage, or a hold
  for (genvar k = 0; k < L; k++) begin : g_iter
    if (k < W) begin : g_sqrt
      rtp_sqrt_stage #(
        .W(W)
      ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .n_in     (n_p[k]),
        .rem_in   (rem_p[k]),
        .root_in  (root_p[k]),
        .n_out    (n_p[k+1]),
        .rem_out  (rem_p[k+1]),
        .root_out (root_p[k+1])
      );
    end else begin : g_sqrt_hold
      always_ff @(posedge clk) begin
        if (en) begin
          n_p[k+1]    <= n_p[k];
          rem_p[k+1]  <= rem_p[k];
          root_p[k+1] <= root_p[k];
        end
      end
    end

    if (k < ITERATIONS) begin : g_rot
      rtp_cordic_stage #(
        .CW    (CW),
        .SHIFT (k)
      ) u_rot (
        .clk   (clk),
        .en    (en),
        .x_in  (cx_p[k]),
        .y_in  (cy_p[k]),
        .z_in  (cz_p[k]),
        .x_out (cx_p[k+1]),
        .y_out (cy_p[k+1]),
        .z_out (cz_p[k+1])
      );
    end else begin : g_rot_hold
      always_ff @(posedge clk) begin
        if (en) begin
          cx_p[k+1] <= cx_p[k];
          cy_p[k+1] <= cy_p[k];
          cz_p[k+1] <= cz_p[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        case_p[k+1] <= case_p[k];
      end
    end
  end

  // Final stage: round the root up when the remainder exceeds it
  assign fin_mag_next = root_p[L] + W'((rem_p[L] > {2'b00, root_p[L]}) ? 1 : 0);

  // Pick the axis answers, else saturate the CORDIC angle to +/-pi
  always_comb begin
    unique case (case_p[L])
      ANG_ZERO:     fin_angle_next = '0;
      ANG_PI:       fin_angle_next = PI_Q13;
      ANG_POS_HALF: fin_angle_next = HALF_PI_Q13;
      ANG_NEG_HALF: fin_angle_next = -HALF_PI_Q13;
      ANG_CORDIC: begin
        priority if (cz_p[L] > PI_Q13) begin
          fin_angle_next = PI_Q13;
        end else if (cz_p[L] < -PI_Q13) begin
          fin_angle_next = -PI_Q13;
        end else begin
          fin_angle_next = cz_p[L];
        end
      end
      default:      fin_angle_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_mag   <= fin_mag_next;
      fin_angle <= fin_angle_next;
    end
  end

  assign fin_data = OUT_TW'({fin_angle, fin_mag});

  // Output register plus skid slot
  rtp_out_buf #(
    .DW(OUT_TW)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fin_valid),
    .in_data  (fin_data),
    .in_ready (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A stall only comes from a result waiting at the output
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  // A stalled pipeline keeps its last result
  a_stall_holds_final: assert property (@(posedge clk) disable iff (rst)
    (!s_tready && fin_valid) |=> fin_valid)
    else $error("final stage lost a transaction during a stall");

  // The angle leaving the last stage stays within -pi .. +pi
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    fin_valid |-> ((fin_angle <= PI_Q13) && (fin_angle >= -PI_Q13)))
    else $error("angle out of range");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  import rtp_pkg::*;

  // Block configuration and derived bus widths
  localparam int DATA_W = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int S_W = ((2 * DATA_W + 7) / 8) * 8;
  localparam int M_W = ((DATA_W + ANGLE_W + 7) / 8) * 8;

  // Base of the final wait for stray results after the drain
  localparam int PIPE_LATENCY = 20;

  // Angle constants in Q3.13 radians
  localparam longint ANG_HALF_PI = 12868;
  localparam longint ANG_PI = 25736;

  // round(atan(2^-i) * 8192) for the stages used here
  localparam longint ARCTAN_Q13 [0:15] = '{
    6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0
  };

  localparam int RANDOM_POINTS = 1950;
  localparam int BUSY_PCT = 38;
  localparam int HOLD_OFF_CYCLES = 200;

  // One polar result as it appears on m_tdata
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic        [DATA_W-1:0]  magnitude;
  } polar_t;

  // One outstanding result, with the point that caused it for messages
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    polar_t                   res;
  } pending_polar_t;

  // Directed row: the point, and a literal result where one is obvious
  typedef struct packed {
    logic signed [DATA_W-1:0]  x;
    logic signed [DATA_W-1:0]  y;
    logic                      given;
    logic        [DATA_W-1:0]  magnitude;
    logic signed [ANGLE_W-1:0] angle;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;

  // Origin, the four axis directions at small and extreme radius, then points
  // in every quadrant, the corners of the range and vectors hugging the
  // negative x axis where the angle accumulator is closest to saturating.
  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{0, 0, 1, 0, 0},
    '{100, 0, 1, 100, 0},
    '{-100, 0, 1, 100, 25736},
    '{0, 100, 1, 100, 12868},
    '{0, -100, 1, 100, -12868},
    '{32767, 0, 1, 32767, 0},
    '{-32768, 0, 1, 32768, 25736},
    '{0, 32767, 1, 32767, 12868},
    '{0, -32768, 1, 32768, -12868},
    '{1, 0, 1, 1, 0},
    '{-1, 0, 1, 1, 25736},
    '{0, 1, 1, 1, 12868},
    '{0, -1, 1, 1, -12868},
    '{3, 4, 0, 0, 0},
    '{-3, -4, 0, 0, 0},
    '{1, 1, 0, 0, 0},
    '{-1, 1, 0, 0, 0},
    '{-1, -1, 0, 0, 0},
    '{32767, 32767, 0, 0, 0},
    '{-32768, -32768, 0, 0, 0},
    '{-32768, 32767, 0, 0, 0},
    '{32767, -32768, 0, 0, 0},
    '{-32768, -1, 0, 0, 0},
    '{-32768, 1, 0, 0, 0},
    '{32767, -1, 0, 0, 0}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  // s_tdata, from bit 0: x_coord, y_coord
  logic [S_W-1:0] s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  // m_tdata, from bit 0: magnitude, angle
  logic [M_W-1:0] m_tdata;

  pending_polar_t pending_results [$];
  pending_polar_t oldest;
  polar_t         observed;

  int src_idle_pct = BUSY_PCT;
  int sink_idle_pct = BUSY_PCT;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int points_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;

  rect_to_polar_converter #(
    .DATA_WIDTH(DATA_W),
    .ITERATIONS(CORDIC_STAGES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legitimate run
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // Polar form of one point: exact rounded integer root for the magnitude,
  // vectoring CORDIC on 16 guard bits for the angle.
  function automatic polar_t polar_of(logic signed [DATA_W-1:0] x,
                                      logic signed [DATA_W-1:0] y);
    longint          xl;
    longint          yl;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    longint          cx;
    longint          cy;
    longint          nx;
    longint          z;
    polar_t          res;
    xl = x;
    yl = y;
    rem = longint'(xl * xl) + longint'(yl * yl);
    root = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    // Round to nearest: step up when the remainder passes the root
    if (rem > root) root = root + 1;

    z = 0;
    if (yl == 0) begin
      z = (xl < 0) ? ANG_PI : 0;
    end else if (xl == 0) begin
      z = (yl > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
    end else begin
      cx = xl * 65536;
      cy = yl * 65536;
      // Fold the left half plane into the right by a quarter turn
      if (cx < 0) begin
        if (cy > 0) begin
          nx = cy;
          cy = -cx;
          cx = nx;
          z = ANG_HALF_PI;
        end else begin
          nx = -cy;
          cy = cx;
          cx = nx;
          z = -ANG_HALF_PI;
        end
      end
      // Drive y toward zero; arithmetic shifts floor toward minus infinity
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (cy >= 0) begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          z = z + ARCTAN_Q13[i];
        end else begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          z = z - ARCTAN_Q13[i];
        end
        cx = nx;
      end
      if (z > ANG_PI) z = ANG_PI;
      if (z < -ANG_PI) z = -ANG_PI;
    end
    res.magnitude = root[DATA_W-1:0];
    res.angle = z[ANGLE_W-1:0];
    return res;
  endfunction

  function automatic void report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $time, what);
  endfunction

  // Offer one point at the falling edge, idling at random first; hold it
  // until the block takes it, then log the result it must produce.
  task automatic send_point(input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] y,
                            input logic given, input polar_t given_res);
    pending_polar_t entry;
    entry.x = x;
    entry.y = y;
    entry.res = given ? given_res : polar_of(x, y);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(entry);
    points_sent++;
  endtask

  // Drop valid and hold the source until every logged result has arrived
  task automatic pause_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random point: mostly full range, with small radii, axis points,
  // corner values and near-negative-x-axis vectors mixed in.
  task automatic random_point(output logic signed [DATA_W-1:0] x,
                              output logic signed [DATA_W-1:0] y);
    int pick;
    int corner [0:6];
    corner = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    pick = $urandom_range(99);
    if (pick < 55) begin
      x = DATA_W'($urandom);
      y = DATA_W'($urandom);
    end else if (pick < 70) begin
      x = DATA_W'(int'($urandom_range(16)) - 8);
      y = DATA_W'(int'($urandom_range(16)) - 8);
    end else if (pick < 80) begin
      x = DATA_W'($urandom);
      y = DATA_W'($urandom);
      if ($urandom_range(1)) x = '0;
      else y = '0;
    end else if (pick < 90) begin
      x = DATA_W'(corner[$urandom_range(6)]);
      y = DATA_W'(corner[$urandom_range(6)]);
    end else begin
      x = DATA_W'(-int'($urandom_range(32768, 16384)));
      y = DATA_W'(int'($urandom_range(64)) - 32);
    end
  endtask

  // Output ready: a pending long hold-off wins, otherwise idle at random
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare every output transaction, field by field, with the oldest
  // logged result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      observed = m_tdata[DATA_W+ANGLE_W-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none outstanding: mag %0d angle %0d",
                                  observed.magnitude, observed.angle));
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (observed.magnitude !== oldest.res.magnitude)
          report_mismatch($sformatf("(%0d,%0d) magnitude exp %0d got %0d",
                                    oldest.x, oldest.y, oldest.res.magnitude,
                                    observed.magnitude));
        if (observed.angle !== oldest.res.angle)
          report_mismatch($sformatf("(%0d,%0d) angle exp %0d got %0d",
                                    oldest.x, oldest.y, oldest.res.angle,
                                    observed.angle));
      end
    end
  end

  initial begin
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    polar_t                   lit;

    // Hold reset, then release it at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      lit.magnitude = directed_rows[r].magnitude;
      lit.angle = directed_rows[r].angle;
      send_point(directed_rows[r].x, directed_rows[r].y, directed_rows[r].given, lit);
    end
    pause_until_drained();

    lit = '0;
    for (int k = 0; k < RANDOM_POINTS; k++) begin
      // Run a long stretch with no idling on either side
      if (k == 400) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (k == 700) begin
        src_idle_pct = BUSY_PCT;
        sink_idle_pct = BUSY_PCT;
      end
      // Stall the output for a long stretch while the source keeps pushing,
      // so the pipeline and its output buffer fill and input ready drops
      if (k == 900) begin
        src_idle_pct = 0;
        hold_requests++;
      end
      if (k == 1000) src_idle_pct = BUSY_PCT;
      // Hold the source until the block has emptied
      if (k == 1300) pause_until_drained();
      random_point(px, py);
      send_point(px, py, 1'b0, lit);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Catch any stray transaction after the last logged result
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("Sent %0d points (%0d table rows), checked %0d results, %0d mismatches.",
             points_sent, DIRECTED_ROWS, results_checked, mismatch_count);
    $display("Covered origin, axes, range corners, random stalls, output hold-off, drain.");
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== rect_to_polar_converter.f =====
rtl/core/rtp_pkg.sv
rtl/core/rtp_cordic_stage.sv
rtl/core/rtp_sqrt_stage.sv
rtl/core/rtp_out_buf.sv
rtl/core/rect_to_polar_converter.sv
test/testbench.sv
